[design/multilevel_process_picker_macros.svh]
// assertion macros for the multilevel process picker
// used by the checker module; expects clk_i and rst_ni in scope
`ifndef MULTILEVEL_PROCESS_PICKER_MACROS_SVH
`define MULTILEVEL_PROCESS_PICKER_MACROS_SVH

// same-cycle implication
`define MLPP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLPP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mlpp_pkg.sv]
// types and constants of the multilevel process picker
// no dependencies; used by every module of the block
package mlpp_pkg;

  localparam logic [2:0] OP_FRESH   = 3'd0;
  localparam logic [2:0] OP_RATIOS  = 3'd1;
  localparam logic [2:0] OP_SCHED   = 3'd2;
  localparam logic [2:0] OP_RUNDONE = 3'd3;
  localparam logic [2:0] OP_SETRUN  = 3'd4;
  localparam logic [2:0] OP_UPDATE  = 3'd5;

  localparam logic [1:0] Q_RR  = 2'd0;
  localparam logic [1:0] Q_LOT = 2'd1;
  localparam logic [1:0] Q_BJF = 2'd2;

  localparam logic [5:0] DIV_STEPS = 6'd32;
  localparam logic [31:0] AGING_RESET = 32'd10000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  slot;
    logic        runnable;
    logic [1:0]  queue_sel;
    logic [15:0] ticket_count_in;
    logic [15:0] priority_ratio_in;
    logic [15:0] arrival_ratio_in;
    logic [15:0] exec_ratio_in;
    logic [31:0] arrival_stamp;
    logic [31:0] now_ticks;
    logic [31:0] elapsed;
  } req_t;

  typedef struct packed {
    logic       pick_valid;
    logic [5:0] pick_slot;
    logic [1:0] pick_queue;
  } res_t;

  typedef struct packed {
    logic        run;
    logic [1:0]  que;
    logic [15:0] tickets;
    logic [15:0] prio;
    logic [15:0] arr_ratio;
    logic [15:0] exe_ratio;
    logic [31:0] arr_time;
    logic [31:0] exe_tenths;
    logic [31:0] waited;
  } ent_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_ONE_RD, ST_ONE_WR, ST_SWP_RD, ST_SWP_WR,
    ST_RR_RD, ST_RR_CHK, ST_LT_RD, ST_LT_CHK, ST_LT_TOT, ST_MOD,
    ST_LS_RD, ST_LS_CHK, ST_BJ_RD, ST_BJ_CHK, ST_BJ_DIV, ST_BJ_MUL,
    ST_BJ_SUM, ST_BJ_CMP, ST_BJ_END, ST_AG_RD, ST_AG_WR, ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_ZERO, PTR_RR, PTR_SLOT, PTR_INC
  } ptr_e;

  typedef enum logic [2:0] {
    WR_FRESH, WR_RUN, WR_UPD, WR_RATIO, WR_WAIT, WR_AGE
  } wr_e;

  typedef struct packed {
    logic       take;
    ptr_e       ptr;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       rd;
    logic       wr;
    wr_e        wmode;
    logic [1:0] lvl;
    logic       acc_clr;
    logic       acc_add;
    logic       div_go;
    logic       div_mod;
    logic       draw_ld;
    logic       share_ld;
    logic       mul_en;
    logic       rank_ld;
    logic       pick;
    logic       rr_upd;
    logic       found_clr;
    logic       res_ld;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       in_table;
    logic       last;
    logic       cnt_last;
    logic       elig;
    logic       lot_hit;
    logic       tot_zero;
    logic       div_done;
    logic       better;
    logic       found;
  } sts_t;

endpackage

[design/mlpp_ctrl.sv]
// controller state machine of the multilevel process picker
// depends on mlpp_pkg; drives the datapath by command, reads its status
module mlpp_ctrl import mlpp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DISP;
      end
      ST_DISP: begin
        unique case (sts_i.op)
          OP_FRESH:              state_d = sts_i.in_table ? ST_ONE_WR : ST_FIN;
          OP_SETRUN, OP_UPDATE:  state_d = sts_i.in_table ? ST_ONE_RD : ST_FIN;
          OP_RATIOS:             state_d = ST_SWP_RD;
          OP_RUNDONE:            state_d = sts_i.in_table ? ST_SWP_RD : ST_FIN;
          OP_SCHED:              state_d = ST_RR_RD;
          default:               state_d = ST_FIN;
        endcase
      end
      ST_ONE_RD: state_d = ST_ONE_WR;
      ST_ONE_WR: state_d = ST_FIN;
      ST_SWP_RD: state_d = ST_SWP_WR;
      ST_SWP_WR: state_d = sts_i.last ? ST_FIN : ST_SWP_RD;
      ST_RR_RD:  state_d = ST_RR_CHK;
      ST_RR_CHK: begin
        if (sts_i.elig)          state_d = ST_AG_RD;
        else if (sts_i.cnt_last) state_d = ST_LT_RD;
        else                     state_d = ST_RR_RD;
      end
      ST_LT_RD:  state_d = ST_LT_CHK;
      ST_LT_CHK: state_d = sts_i.last ? ST_LT_TOT : ST_LT_RD;
      ST_LT_TOT: state_d = sts_i.tot_zero ? ST_BJ_RD : ST_MOD;
      ST_MOD: begin
        if (sts_i.div_done) state_d = ST_LS_RD;
      end
      ST_LS_RD:  state_d = ST_LS_CHK;
      ST_LS_CHK: begin
        if (sts_i.lot_hit)   state_d = ST_AG_RD;
        else if (sts_i.last) state_d = ST_BJ_RD;
        else                 state_d = ST_LS_RD;
      end
      ST_BJ_RD:  state_d = ST_BJ_CHK;
      ST_BJ_CHK: begin
        if (sts_i.elig)      state_d = ST_BJ_DIV;
        else if (sts_i.last) state_d = ST_BJ_END;
        else                 state_d = ST_BJ_RD;
      end
      ST_BJ_DIV: begin
        if (sts_i.div_done) state_d = ST_BJ_MUL;
      end
      ST_BJ_MUL: state_d = ST_BJ_SUM;
      ST_BJ_SUM: state_d = ST_BJ_CMP;
      ST_BJ_CMP: state_d = sts_i.last ? ST_BJ_END : ST_BJ_RD;
      ST_BJ_END: state_d = sts_i.found ? ST_AG_RD : ST_FIN;
      ST_AG_RD:  state_d = ST_AG_WR;
      ST_AG_WR:  state_d = sts_i.last ? ST_FIN : ST_AG_RD;
      ST_FIN:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: cmd_o.take = start_i;
      ST_DISP: begin
        cmd_o.found_clr = 1'b1;
        cmd_o.acc_clr = 1'b1;
        unique case (sts_i.op)
          OP_FRESH, OP_SETRUN, OP_UPDATE: cmd_o.ptr = PTR_SLOT;
          OP_RATIOS, OP_RUNDONE:          cmd_o.ptr = PTR_ZERO;
          OP_SCHED: begin
            cmd_o.ptr = PTR_RR;
            cmd_o.cnt_clr = 1'b1;
          end
          default: cmd_o.ptr = PTR_HOLD;
        endcase
      end
      ST_ONE_RD, ST_SWP_RD, ST_RR_RD, ST_LT_RD, ST_LS_RD, ST_BJ_RD, ST_AG_RD: begin
        cmd_o.rd = 1'b1;
      end
      ST_ONE_WR: begin
        cmd_o.wr = 1'b1;
        if (sts_i.op == OP_FRESH)       cmd_o.wmode = WR_FRESH;
        else if (sts_i.op == OP_SETRUN) cmd_o.wmode = WR_RUN;
        else                            cmd_o.wmode = WR_UPD;
      end
      ST_SWP_WR: begin
        cmd_o.wr = 1'b1;
        cmd_o.wmode = (sts_i.op == OP_RATIOS) ? WR_RATIO : WR_WAIT;
        cmd_o.ptr = PTR_INC;
      end
      ST_RR_CHK: begin
        cmd_o.lvl = Q_RR;
        if (sts_i.elig) begin
          cmd_o.pick = 1'b1;
          cmd_o.rr_upd = 1'b1;
          cmd_o.ptr = PTR_ZERO;
        end else if (sts_i.cnt_last) begin
          cmd_o.ptr = PTR_ZERO;
        end else begin
          cmd_o.ptr = PTR_INC;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_LT_CHK: begin
        cmd_o.lvl = Q_LOT;
        cmd_o.acc_add = 1'b1;
        cmd_o.ptr = PTR_INC;
      end
      ST_LT_TOT: begin
        if (!sts_i.tot_zero) begin
          cmd_o.div_go = 1'b1;
          cmd_o.div_mod = 1'b1;
          cmd_o.acc_clr = 1'b1;
        end
      end
      ST_MOD: cmd_o.draw_ld = sts_i.div_done;
      ST_LS_CHK: begin
        cmd_o.lvl = Q_LOT;
        if (sts_i.lot_hit) begin
          cmd_o.pick = 1'b1;
          cmd_o.ptr = PTR_ZERO;
        end else begin
          cmd_o.acc_add = 1'b1;
          cmd_o.ptr = PTR_INC;
        end
      end
      ST_BJ_CHK: begin
        cmd_o.lvl = Q_BJF;
        if (sts_i.elig) cmd_o.div_go = 1'b1;
        else            cmd_o.ptr = PTR_INC;
      end
      ST_BJ_DIV: cmd_o.share_ld = sts_i.div_done;
      ST_BJ_MUL: cmd_o.mul_en = 1'b1;
      ST_BJ_SUM: cmd_o.rank_ld = 1'b1;
      ST_BJ_CMP: begin
        cmd_o.lvl = Q_BJF;
        cmd_o.pick = sts_i.better;
        cmd_o.ptr = PTR_INC;
      end
      ST_BJ_END: cmd_o.ptr = PTR_ZERO;
      ST_AG_WR: begin
        cmd_o.wr = 1'b1;
        cmd_o.wmode = WR_AGE;
        cmd_o.ptr = PTR_INC;
      end
      ST_FIN: cmd_o.res_ld = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

[design/mlpp_dpath.sv]
// datapath of the multilevel process picker: slot table, scan pointer,
// ticket accumulator, shared serial divider, rank unit; depends on mlpp_pkg
module mlpp_dpath import mlpp_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output res_t        res_o,
  output logic        done_o
);

  localparam int PW = $clog2(SLOTS);
  localparam int TW = 16 + $clog2(SLOTS);
  localparam int RW = 52;

  ent_t              mem [SLOTS];
  logic [SLOTS-1:0]  valid_q;
  ent_t              rd_q;
  logic              rdv_q;
  ent_t              ed;
  ent_t              wdata;

  req_t              req_q;
  logic [31:0]       limit_q;
  logic [PW-1:0]     ptr_q, cnt_q, rr_q, chosen_q;
  logic [1:0]        level_q;
  logic              found_q;
  logic [TW-1:0]     acc_q, draw_q, acc_sum;
  logic [15:0]       share_q;
  logic [47:0]       m1_q, m2_q;
  logic [RW-1:0]     rank_q, best_q, rank_d, base;
  res_t              res_q;
  logic              done_q;

  logic [31:0]       dq_q;
  logic [TW-1:0]     dvs_q, rem_q;
  logic [5:0]        dcnt_q;
  logic [TW:0]       r_sh, r_sub;
  logic              r_ge;

  logic              hit_slot;
  logic              run_new;
  logic [32:0]       wsum;

  assign ed = rdv_q ? rd_q : '0;
  assign acc_sum = acc_q + TW'(ed.tickets);

  // status
  always_comb begin
    sts_o.op = req_q.opcode;
    sts_o.in_table = ({26'd0, req_q.slot} < 32'(SLOTS));
    sts_o.last = (ptr_q == PW'(SLOTS - 1));
    sts_o.cnt_last = (cnt_q == PW'(SLOTS - 1));
    sts_o.elig = ed.run && (ed.que == cmd_i.lvl);
    sts_o.lot_hit = sts_o.elig && (draw_q < acc_sum);
    sts_o.tot_zero = (acc_q == '0);
    sts_o.div_done = (dcnt_q == DIV_STEPS);
    sts_o.better = !found_q || (rank_q < best_q);
    sts_o.found = found_q;
  end

  // write data per mode
  assign hit_slot = (ptr_q == PW'(req_q.slot));
  assign run_new = hit_slot ? req_q.runnable : ed.run;
  assign wsum = {1'b0, ed.waited} + {1'b0, req_q.elapsed};

  always_comb begin
    wdata = ed;
    case (cmd_i.wmode)
      WR_FRESH: begin
        wdata.run = req_q.runnable;
        wdata.que = req_q.queue_sel;
        wdata.tickets = req_q.ticket_count_in;
        wdata.prio = req_q.priority_ratio_in;
        wdata.arr_ratio = req_q.arrival_ratio_in;
        wdata.exe_ratio = req_q.exec_ratio_in;
        wdata.arr_time = req_q.arrival_stamp;
        wdata.exe_tenths = '0;
        wdata.waited = '0;
      end
      WR_RUN: wdata.run = req_q.runnable;
      WR_UPD: begin
        wdata.que = req_q.queue_sel;
        wdata.tickets = req_q.ticket_count_in;
        wdata.prio = req_q.priority_ratio_in;
        wdata.arr_ratio = req_q.arrival_ratio_in;
        wdata.exe_ratio = req_q.exec_ratio_in;
      end
      WR_RATIO: begin
        wdata.prio = req_q.priority_ratio_in;
        wdata.arr_ratio = req_q.arrival_ratio_in;
        wdata.exe_ratio = req_q.exec_ratio_in;
      end
      WR_WAIT: begin
        wdata.run = run_new;
        if (hit_slot)     wdata.waited = '0;
        else if (run_new) wdata.waited = wsum[32] ? '1 : wsum[31:0];
      end
      WR_AGE: begin
        if (ed.run && (ed.waited > limit_q)) begin
          wdata.waited = '0;
          if (ed.que == Q_LOT)      wdata.que = Q_RR;
          else if (ed.que == Q_BJF) wdata.que = Q_LOT;
        end
        if ((ptr_q == chosen_q) && (ed.exe_tenths != '1)) begin
          wdata.exe_tenths = ed.exe_tenths + 32'd1;
        end
      end
      default: wdata = ed;
    endcase
  end

  // slot table
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[ptr_q];
    if (cmd_i.wr) mem[ptr_q] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      if (cmd_i.rd) rdv_q <= valid_q[ptr_q];
      if (cmd_i.wr) valid_q[ptr_q] <= 1'b1;
    end
  end

  // serial divider, one quotient bit per cycle
  assign r_sh = {rem_q, dq_q[31]};
  assign r_ge = (r_sh >= {1'b0, dvs_q});
  assign r_sub = r_ge ? (r_sh - {1'b0, dvs_q}) : r_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= DIV_STEPS;
    end else if (cmd_i.div_go) begin
      dcnt_q <= '0;
    end else if (dcnt_q != DIV_STEPS) begin
      dcnt_q <= dcnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      rem_q <= '0;
      if (cmd_i.div_mod) begin
        dq_q <= req_q.now_ticks;
        dvs_q <= acc_q;
      end else begin
        dq_q <= {16'd0, ed.prio};
        dvs_q <= TW'(ed.tickets);
      end
    end else if (dcnt_q != DIV_STEPS) begin
      rem_q <= r_sub[TW-1:0];
      dq_q <= {dq_q[30:0], r_ge};
    end
  end

  // rank
  assign base = RW'(m1_q) + RW'(share_q);
  assign rank_d = (base << 3) + (base << 1) + RW'(m2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) req_q <= req_i;
    if (cmd_i.draw_ld) draw_q <= rem_q;
    if (cmd_i.share_ld) share_q <= (ed.tickets == '0) ? '0 : dq_q[15:0];
    if (cmd_i.mul_en) begin
      m1_q <= ed.arr_time * ed.arr_ratio;
      m2_q <= ed.exe_tenths * ed.exe_ratio;
    end
    if (cmd_i.rank_ld) rank_q <= rank_d;
    if (cmd_i.pick) begin
      chosen_q <= ptr_q;
      level_q <= cmd_i.lvl;
      best_q <= rank_q;
    end
    if (cmd_i.res_ld) begin
      res_q.pick_valid <= found_q;
      res_q.pick_slot <= found_q ? 6'(chosen_q) : '0;
      res_q.pick_queue <= found_q ? level_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= AGING_RESET;
      ptr_q <= '0;
      cnt_q <= '0;
      rr_q <= '0;
      acc_q <= '0;
      found_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      case (cmd_i.ptr)
        PTR_ZERO: ptr_q <= '0;
        PTR_RR:   ptr_q <= rr_q;
        PTR_SLOT: ptr_q <= PW'(req_q.slot);
        PTR_INC:  ptr_q <= (ptr_q == PW'(SLOTS - 1)) ? '0 : ptr_q + PW'(1);
        default:  ptr_q <= ptr_q;
      endcase
      if (cmd_i.cnt_clr)      cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + PW'(1);
      if (cmd_i.rr_upd) rr_q <= (ptr_q == PW'(SLOTS - 1)) ? '0 : ptr_q + PW'(1);
      if (cmd_i.acc_clr)                    acc_q <= '0;
      else if (cmd_i.acc_add && sts_o.elig) acc_q <= acc_sum;
      if (cmd_i.found_clr) found_q <= 1'b0;
      else if (cmd_i.pick) found_q <= 1'b1;
      done_q <= cmd_i.res_ld;
    end
  end

  assign res_o = res_q;
  assign done_o = done_q;

endmodule

[design/multilevel_process_picker.sv]
// top level of the multilevel process picker
// depends on mlpp_pkg, mlpp_ctrl and mlpp_dpath
//
// One command at a time: start_i is taken when busy_o is low, and exactly one
// result follows on res_o for the single cycle in which done_o is high. The
// slot table is one single-port memory, read and written one slot at a time;
// the set-ratios, run-done, ticket total, best-job-first and aging sweeps walk
// all SLOTS slots, and the round-robin and draw scans stop at a pick. A fresh
// write only writes its slot, set-runnable and update read and write it, and
// set-ratios and run-done every slot. A slot outside the table or an unused
// opcode goes straight to finish. A schedule command runs the round-robin scan,
// then if needed the lottery (ticket total, serial modulo, draw scan), then if
// needed best-job-first (each rank needs a pass of the same serial divider and
// a multiply), and the aging sweep after a pick. Per-slot valid bits clear at
// reset, so no clearing pass is needed. The result cannot be stalled.
module multilevel_process_picker import mlpp_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        done_o,
  output res_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mlpp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  mlpp_dpath #(
    .SLOTS(SLOTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o),
    .done_o     (done_o)
  );

endmodule

[design/mlpp_checker.sv]
// port-level checks of the multilevel process picker and their bind
// depends on mlpp_pkg and multilevel_process_picker_macros.svh
`include "multilevel_process_picker_macros.svh"

module mlpp_checker import mlpp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input res_t res_o
);

  `MLPP_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result while busy")
  `MLPP_ASSERT_NXT(a_take_busy, start_i && !busy_o, busy_o, "transaction not taken")
  `MLPP_ASSERT_IMP(a_no_pick_zero, done_o && !res_o.pick_valid,
                   res_o.pick_slot == 6'd0 && res_o.pick_queue == Q_RR, "empty result not zero")
  `MLPP_ASSERT_IMP(a_pick_level, done_o && res_o.pick_valid,
                   res_o.pick_queue == Q_RR || res_o.pick_queue == Q_LOT ||
                   res_o.pick_queue == Q_BJF, "bad pick level")

endmodule

bind multilevel_process_picker mlpp_checker u_chk (.*);

[bench/multilevel_process_picker_tb.sv]
// testbench for the multilevel process picker: directed and random commands
// checked against an in-bench model of the slot table; depends on mlpp_pkg
module multilevel_process_picker_tb;
  import mlpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t req = '0;
  logic busy, done;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  multilevel_process_picker #(.SLOTS(SLOTS)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .req_i(req), .busy_o(busy),
    .done_o(done), .res_o(res), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the slot table
  logic        m_run[SLOTS];
  logic [1:0]  m_que[SLOTS];
  logic [15:0] m_tk[SLOTS], m_pr[SLOTS], m_ar[SLOTS], m_er[SLOTS];
  logic [31:0] m_arr[SLOTS], m_exe[SLOTS], m_wait[SLOTS];
  logic [5:0]  m_rr;
  logic [31:0] m_limit;

  res_t picks_due[$];
  int errors = 0;
  int n_sent = 0, n_picks = 0, n_levels[3] = '{0, 0, 0};
  int idle_cycles = 0;

  function automatic logic [63:0] rank(int s);
    logic [63:0] share;
    share = (m_tk[s] != 0) ? 64'(m_pr[s] / m_tk[s]) : 64'd0;
    return 64'd10 * share + 64'd10 * 64'(m_arr[s]) * 64'(m_ar[s])
      + 64'(m_exe[s]) * 64'(m_er[s]);
  endfunction

  function automatic res_t schedule(logic [31:0] now);
    res_t r;
    bit ok;
    int ch, s;
    logic [31:0] total, acc, draw;
    logic [63:0] best, rk;
    r = '0; ok = 0; ch = 0;
    for (int i = 0; i < SLOTS && !ok; i++) begin
      s = (int'(m_rr) + i) % SLOTS;
      if (m_run[s] && m_que[s] == Q_RR) begin
        ok = 1; ch = s; m_rr = 6'((s + 1) % SLOTS); r.pick_queue = Q_RR;
      end
    end
    if (!ok) begin
      total = 0; acc = 0;
      for (s = 0; s < SLOTS; s++)
        if (m_run[s] && m_que[s] == Q_LOT) total += m_tk[s];
      if (total != 0) begin
        draw = now % total;
        for (s = 0; s < SLOTS && !ok; s++)
          if (m_run[s] && m_que[s] == Q_LOT) begin
            acc += m_tk[s];
            if (draw < acc) begin
              ok = 1; ch = s; r.pick_queue = Q_LOT;
            end
          end
      end
    end
    if (!ok) begin
      best = 0;
      for (s = 0; s < SLOTS; s++)
        if (m_run[s] && m_que[s] == Q_BJF) begin
          rk = rank(s);
          if (!ok || rk < best) begin
            ok = 1; best = rk; ch = s; r.pick_queue = Q_BJF;
          end
        end
    end
    if (ok) begin
      for (s = 0; s < SLOTS; s++)
        if (m_run[s] && m_wait[s] > m_limit) begin
          m_wait[s] = 0;
          if (m_que[s] == Q_LOT) m_que[s] = Q_RR;
          else if (m_que[s] == Q_BJF) m_que[s] = Q_LOT;
        end
      if (m_exe[ch] != '1) m_exe[ch]++;
      r.pick_valid = 1'b1;
      r.pick_slot = 6'(ch);
    end
    return r;
  endfunction

  function automatic res_t apply_cmd(req_t q);
    res_t r;
    logic [32:0] w;
    r = '0;
    case (q.opcode)
      OP_FRESH: begin
        m_run[q.slot] = q.runnable; m_que[q.slot] = q.queue_sel;
        m_tk[q.slot] = q.ticket_count_in; m_pr[q.slot] = q.priority_ratio_in;
        m_ar[q.slot] = q.arrival_ratio_in; m_er[q.slot] = q.exec_ratio_in;
        m_arr[q.slot] = q.arrival_stamp; m_exe[q.slot] = 0; m_wait[q.slot] = 0;
      end
      OP_RATIOS:
        for (int s = 0; s < SLOTS; s++) begin
          m_pr[s] = q.priority_ratio_in; m_ar[s] = q.arrival_ratio_in;
          m_er[s] = q.exec_ratio_in;
        end
      OP_SCHED: r = schedule(q.now_ticks);
      OP_RUNDONE: begin
        m_run[q.slot] = q.runnable;
        for (int s = 0; s < SLOTS; s++)
          if (m_run[s]) begin
            w = 33'(m_wait[s]) + 33'(q.elapsed);
            m_wait[s] = w[32] ? 32'hFFFF_FFFF : w[31:0];
          end
        m_wait[q.slot] = 0;
      end
      OP_SETRUN: m_run[q.slot] = q.runnable;
      OP_UPDATE: begin
        m_que[q.slot] = q.queue_sel; m_tk[q.slot] = q.ticket_count_in;
        m_pr[q.slot] = q.priority_ratio_in; m_ar[q.slot] = q.arrival_ratio_in;
        m_er[q.slot] = q.exec_ratio_in;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(req_t q, int gap);
    res_t r;
    @(posedge clk);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    req <= q;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    r = apply_cmd(q);
    picks_due.push_back(r);
    n_sent++;
    if (r.pick_valid) begin
      n_picks++;
      n_levels[r.pick_queue]++;
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (picks_due.size() != 0 && guard < WATCH_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (600) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_limit = v;
  endtask

  function automatic req_t rand_req(int op);
    req_t q;
    q.opcode = 3'(op);
    q.slot = 6'($urandom_range(0, 63));
    q.runnable = 1'($urandom);
    q.queue_sel = 2'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
    q.ticket_count_in = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    q.priority_ratio_in = 16'($urandom);
    q.arrival_ratio_in = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    q.exec_ratio_in = 16'($urandom);
    q.arrival_stamp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
    q.now_ticks = $urandom;
    q.elapsed = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FF00 | $urandom : $urandom_range(0, 6000);
    return q;
  endfunction

  task automatic test_directed();
    req_t q;
    q = '0; q.opcode = OP_SCHED; send(q, 0);          // empty table
    q = '1; q.opcode = OP_FRESH; q.queue_sel = Q_BJF; send(q, 1);
    q = '0; q.opcode = OP_FRESH; q.slot = 0; q.runnable = 1; q.queue_sel = Q_BJF;
    send(q, 0);
    q = '0; q.opcode = OP_SCHED; send(q, 0);          // lower rank wins
    q = '0; q.opcode = OP_FRESH; q.slot = 5; q.runnable = 1; q.queue_sel = Q_LOT;
    send(q, 0);
    q = '0; q.opcode = OP_SCHED; send(q, 2);          // zero tickets skip lottery
    q = '0; q.opcode = OP_UPDATE; q.slot = 5; q.queue_sel = Q_LOT;
    q.ticket_count_in = 16'hFFFF; send(q, 0);
    q = '0; q.opcode = OP_SCHED; q.now_ticks = '1; send(q, 0);
    q = '0; q.opcode = OP_FRESH; q.slot = 63; q.runnable = 1; q.queue_sel = Q_RR;
    send(q, 0);
    q = '0; q.opcode = OP_FRESH; q.slot = 7; q.runnable = 1; q.queue_sel = 2'd3;
    send(q, 0);
    q = '0; q.opcode = OP_SCHED; send(q, 0);          // rr wraps
    q = '0; q.opcode = OP_SCHED; send(q, 0);
    q = '1; q.opcode = OP_RATIOS; send(q, 3);
    q = '0; q.opcode = OP_RUNDONE; q.slot = 0; q.runnable = 1; q.elapsed = '1;
    send(q, 0);
    q.slot = 1; send(q, 0);                            // saturating wait
    q = '0; q.opcode = OP_SETRUN; q.slot = 63; send(q, 0);
    q = '0; q.opcode = OP_SCHED; send(q, 0);          // aging promotes
    q = '1; q.opcode = 3'd6; send(q, 0);
    q = '1; q.opcode = 3'd7; send(q, 0);
    q = '0; q.opcode = OP_SCHED; send(q, 0);
  endtask

  task automatic test_random(int count);
    int op, k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 15) op = OP_FRESH;
      else if (k < 20) op = OP_RATIOS;
      else if (k < 50) op = OP_SCHED;
      else if (k < 65) op = OP_RUNDONE;
      else if (k < 80) op = OP_SETRUN;
      else if (k < 95) op = OP_UPDATE;
      else op = $urandom_range(6, 7);
      send(rand_req(op), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10));
      if (i == count / 2) drain();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (rst_n && done) begin
      if (picks_due.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        e = picks_due.pop_front();
        if (res.pick_valid !== e.pick_valid) begin
          $error("pick_valid expected %0d actual %0d", e.pick_valid, res.pick_valid);
          errors++;
        end
        if (res.pick_slot !== e.pick_slot) begin
          $error("pick_slot expected %0d actual %0d", e.pick_slot, res.pick_slot);
          errors++;
        end
        if (res.pick_queue !== e.pick_queue) begin
          $error("pick_queue expected %0d actual %0d", e.pick_queue, res.pick_queue);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("multilevel_process_picker_tb: errors");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      m_run[s] = 0; m_que[s] = 0; m_tk[s] = 0; m_pr[s] = 0; m_ar[s] = 0;
      m_er[s] = 0; m_arr[s] = 0; m_exe[s] = 0; m_wait[s] = 0;
    end
    m_rr = 0;
    m_limit = AGING_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_limit(32'd0);
    test_random(300);
    write_limit(32'hFFFF_FFFF);
    test_random(300);
    write_limit(32'd5000);
    test_random(400);
    drain();
    if (picks_due.size() != 0) begin
      $error("%0d results never arrived", picks_due.size());
      errors++;
    end
    $display("covered %0d commands, %0d picks (rr %0d, lottery %0d, bjf %0d)",
             n_sent, n_picks, n_levels[0], n_levels[1], n_levels[2]);
    if (errors == 0) $display("multilevel_process_picker_tb: clean");
    else $display("multilevel_process_picker_tb: errors");
    $finish;
  end
endmodule
